/* design/bollinger_band_window_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the band window block
// Shared implication helpers, reported through $error.
// ----------------------------------------------------------------------------
`ifndef BOLLINGER_BAND_WINDOW_ASSERT_SVH
`define BOLLINGER_BAND_WINDOW_ASSERT_SVH

// Overlapping implication, reset disables.
`define BBW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset disables.
`define BBW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/bbw_pkg.sv */
// ----------------------------------------------------------------------------
// Band window package
// Shared constants and the controller-to-datapath command type.
// ----------------------------------------------------------------------------
package bbw_pkg;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned CfgDataW = 12;
	localparam int unsigned LenW = 7;
	localparam int unsigned MultW = 12;
	localparam int unsigned OutPriceW = 32;
	localparam int unsigned BandW = 37;
	localparam logic [CfgIdxW-1:0] REG_WINDOW_LENGTH = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_BAND_MULTIPLIER = 1'd1;

	typedef struct packed {
		logic load;      // take item into window, clear accumulators
		logic rd;        // issue a window read
		logic acc_sum;   // add read data to sum
		logic acc_sq;    // add squared deviation
		logic div_sum;   // one quotient step of sum/N
		logic div_sq;    // one quotient step of ssd/N
		logic sqrt_step; // one root step
		logic prep_div;  // arm divider with sum
		logic prep_div2; // arm divider with ssd
		logic prep_sqrt; // arm square root
		logic mul;       // band offset multiply
		logic fin;       // form result
	} bbw_cmd_t;
endpackage

/* design/bbw_stream_if.sv */
// ----------------------------------------------------------------------------
// Band window stream interface
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface bbw_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* design/bbw_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bbw_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 64
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule

/* design/bbw_datapath.sv */
// ----------------------------------------------------------------------------
// Band window datapath
// Window memory, accumulators, serial divider, serial root, offset multiply.
// ----------------------------------------------------------------------------
module bbw_datapath #(
	parameter int unsigned WindowMax = 64,
	parameter int unsigned PriceWidth = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  bbw_pkg::bbw_cmd_t cmd,
	input  logic restart,
	input  logic [PriceWidth-1:0] price,
	input  logic [$clog2(WindowMax+1)-1:0] n,
	input  logic [bbw_pkg::MultW-1:0] mult,
	output logic enough,
	output logic [bbw_pkg::OutPriceW-1:0] middle,
	output logic [bbw_pkg::BandW-1:0] upper,
	output logic [bbw_pkg::BandW-1:0] lower,
	output logic [bbw_pkg::OutPriceW-1:0] dev
);
	import bbw_pkg::*;
	localparam int unsigned AW = $clog2(WindowMax);
	localparam int unsigned CW = $clog2(WindowMax+1);
	localparam int unsigned SumW = PriceWidth + CW;
	localparam int unsigned SqW = 2*PriceWidth + CW;
	localparam int unsigned RootW = PriceWidth;

	logic [AW-1:0] wpos_q, rpos_q;
	logic [CW-1:0] fill_q;
	logic [PriceWidth-1:0] rdata;
	logic [SumW-1:0] sum_q;
	logic [SqW-1:0] ssd_q;
	logic [PriceWidth-1:0] mean_q;
	logic [SqW-1:0] dq_q;       // dividend shifting into quotient
	logic [CW:0] drem_q;
	logic [2*RootW-1:0] rad_q;  // radicand shift
	logic [RootW+1:0] rrem_q;
	logic [RootW-1:0] root_q;
	logic [RootW+MultW-1:0] prod_q;
	logic [CW-1:0] fill_n;
	logic [CW:0] drem_sh;
	logic [RootW+1:0] rrem_sh, rtrial;
	logic [PriceWidth-1:0] diff;
	logic [2*PriceWidth-1:0] sq;

	bbw_ram #(.Width(PriceWidth), .Depth(2**AW)) u_ram (
		.clk, .we(cmd.load), .waddr(restart ? '0 : wpos_q), .wdata(price),
		.re(cmd.rd), .raddr(rpos_q), .rdata
	);

	always_comb begin
		fill_n = restart ? CW'(1)
			: ((fill_q == CW'(WindowMax)) ? fill_q : fill_q + CW'(1));
		drem_sh = {drem_q[CW-1:0], dq_q[SqW-1]};
		rrem_sh = {rrem_q[RootW-1:0], rad_q[2*RootW-1 -: 2]};
		rtrial = {root_q, 2'b01};
		// mean still held in the divider during the second walk
		diff = (rdata >= dq_q[PriceWidth-1:0]) ? rdata - dq_q[PriceWidth-1:0]
			: dq_q[PriceWidth-1:0] - rdata;
		sq = diff * diff;
	end

	assign enough = fill_q >= n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0;
			fill_q <= '0;
		end else if (cmd.load) begin
			wpos_q <= (restart ? AW'(0) : wpos_q) + AW'(1);
			fill_q <= fill_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rpos_q <= (restart ? AW'(0) : wpos_q);
			sum_q <= '0;
			ssd_q <= '0;
		end else if (cmd.rd) begin
			rpos_q <= rpos_q - AW'(1);
		end else if (cmd.prep_div) begin
			rpos_q <= wpos_q - AW'(1);
		end
		if (cmd.acc_sum) sum_q <= sum_q + SumW'(rdata);
		if (cmd.acc_sq) ssd_q <= ssd_q + SqW'(sq);
		if (cmd.prep_div) begin
			dq_q <= SqW'(sum_q);
			drem_q <= '0;
		end
		if (cmd.prep_div2) begin
			dq_q <= ssd_q;
			drem_q <= '0;
		end
		if (cmd.div_sum || cmd.div_sq) begin
			if (drem_sh >= {1'b0, n}) begin
				drem_q <= drem_sh - {1'b0, n};
				dq_q <= {dq_q[SqW-2:0], 1'b1};
			end else begin
				drem_q <= drem_sh;
				dq_q <= {dq_q[SqW-2:0], 1'b0};
			end
		end
		if (cmd.prep_sqrt) begin
			// quotient fits 2*PriceWidth bits
			rad_q <= dq_q[2*RootW-1:0];
			rrem_q <= '0;
			root_q <= '0;
			mean_q <= mean_q;
		end
		if (cmd.div_sq == 1'b0 && cmd.prep_div2) mean_q <= dq_q[PriceWidth-1:0];
		if (cmd.sqrt_step) begin
			rad_q <= rad_q << 2;
			if (rrem_sh >= rtrial) begin
				rrem_q <= rrem_sh - rtrial;
				root_q <= {root_q[RootW-2:0], 1'b1};
			end else begin
				rrem_q <= rrem_sh;
				root_q <= {root_q[RootW-2:0], 1'b0};
			end
		end
		if (cmd.mul) prod_q <= root_q * mult;
		if (cmd.fin) begin
			middle <= OutPriceW'(mean_q);
			dev <= OutPriceW'(root_q);
			upper <= BandW'(mean_q) + BandW'(prod_q >> 8);
			lower <= BandW'(mean_q) - BandW'(prod_q >> 8);
		end
	end
endmodule

/* design/bbw_ctrl.sv */
// ----------------------------------------------------------------------------
// Band window controller
// Sequences window walks, division and root steps, holds the result.
// ----------------------------------------------------------------------------
module bbw_ctrl #(
	parameter int unsigned WindowMax = 64,
	parameter int unsigned PriceWidth = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  logic [$clog2(WindowMax+1)-1:0] n,
	input  logic enough,
	output bbw_pkg::bbw_cmd_t cmd
);
	import bbw_pkg::*;
	`include "bollinger_band_window_assert.svh"
	localparam int unsigned CW = $clog2(WindowMax+1);
	localparam int unsigned SqW = 2*PriceWidth + CW;
	localparam int unsigned StW = $clog2(SqW+1);

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_SUM, S_DIV1, S_SQ, S_DIV2, S_ROOT, S_MUL, S_FIN, S_OUT
	} state_t;

	state_t state_q;
	logic [StW-1:0] cnt_q;
	logic [CW-1:0] rd_q;
	logic lag_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		unique case (state_q)
			S_SUM, S_SQ: begin
				cmd.rd = (rd_q != '0);
				cmd.acc_sum = (state_q == S_SUM) && lag_q;
				cmd.acc_sq = (state_q == S_SQ) && lag_q;
			end
			S_DIV1: begin
				cmd.prep_div = (cnt_q == '0);
				cmd.div_sum = (cnt_q != '0);
			end
			S_DIV2: begin
				cmd.prep_div2 = (cnt_q == '0);
				cmd.div_sq = (cnt_q != '0);
			end
			S_ROOT: begin
				cmd.prep_sqrt = (cnt_q == '0);
				cmd.sqrt_step = (cnt_q != '0);
			end
			S_MUL: cmd.mul = 1'b1;
			S_FIN: cmd.fin = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			rd_q <= '0;
			lag_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_CHECK;
				S_CHECK: begin
					if (enough) begin
						state_q <= S_SUM;
						rd_q <= n;
						lag_q <= 1'b0;
					end else state_q <= S_IDLE;
				end
				S_SUM, S_SQ: begin
					lag_q <= (rd_q != '0);
					if (rd_q != '0) rd_q <= rd_q - CW'(1);
					if (rd_q == '0 && !lag_q) begin
						cnt_q <= '0;
						state_q <= (state_q == S_SUM) ? S_DIV1 : S_DIV2;
					end
				end
				S_DIV1, S_DIV2: begin
					if (cnt_q == StW'(SqW)) begin
						cnt_q <= '0;
						if (state_q == S_DIV1) begin
							state_q <= S_SQ;
							rd_q <= n;
							lag_q <= 1'b0;
						end else state_q <= S_ROOT;
					end else cnt_q <= cnt_q + StW'(1);
				end
				S_ROOT: begin
					if (cnt_q == StW'(PriceWidth)) state_q <= S_MUL;
					else cnt_q <= cnt_q + StW'(1);
				end
				S_MUL: state_q <= S_FIN;
				S_FIN: begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BBW_ASSERT_IMP(a_valid_in_out, clk, arst_n, out_valid, state_q == S_OUT, "result outside out state")
	`BBW_ASSERT_NEXT(a_load_check, clk, arst_n, cmd.load, state_q == S_CHECK, "load not followed by check")
	`BBW_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, !in_ready, "ready while busy")
endmodule

/* design/bollinger_band_window.sv */
// ----------------------------------------------------------------------------
// Bollinger band window
// Moving mean, population deviation and bands over the last N prices.
// ----------------------------------------------------------------------------
// channel  dir  payload
// in       sink close_price[32], restart
// out      src  middle_band[32], upper_band[37], lower_band[37], deviation[32]
// cfg      in   cfg_we, cfg_index, cfg_data
// One item at a time. A price with too short a history goes from the check
// straight back to idle with no result. Otherwise the run time is set by
// the single memory read port and the bit-serial divider and root.
// Reset clears window position and fill count; the memory is not cleared.
// A held result stalls the next item until it is taken.
module bollinger_band_window #(
	parameter int unsigned WindowMax = 64,
	parameter int unsigned PriceWidth = 32
) (
	input  logic clk,
	input  logic arst_n,
	bbw_stream_if.sink in_ch,
	bbw_stream_if.source out_ch,
	input  logic cfg_we,
	input  logic [bbw_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [bbw_pkg::CfgDataW-1:0] cfg_data
);
	import bbw_pkg::*;
	localparam int unsigned CW = $clog2(WindowMax+1);

	logic [LenW-1:0] len_q;
	logic [MultW-1:0] mult_q;
	logic [CW-1:0] n;
	bbw_cmd_t cmd;
	logic enough;
	logic [PriceWidth-1:0] price;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LenW'(20);
			mult_q <= MultW'(512);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH: len_q <= cfg_data[LenW-1:0];
				REG_BAND_MULTIPLIER: mult_q <= cfg_data[MultW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (len_q == '0) n = CW'(1);
		else if (32'(len_q) > WindowMax) n = CW'(WindowMax);
		else n = CW'(len_q);
	end

	assign price = PriceWidth'(in_ch.data.close_price);

	bbw_ctrl #(.WindowMax(WindowMax), .PriceWidth(PriceWidth)) u_ctrl (
		.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .n, .enough, .cmd
	);

	bbw_datapath #(.WindowMax(WindowMax), .PriceWidth(PriceWidth)) u_dp (
		.clk, .arst_n, .cmd, .restart(in_ch.data.restart), .price, .n,
		.mult(mult_q), .enough,
		.middle(out_ch.data.middle_band), .upper(out_ch.data.upper_band),
		.lower(out_ch.data.lower_band), .dev(out_ch.data.deviation)
	);
endmodule

/* bench/tb_bollinger_band_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Band window testbench
// Streams prices through the block under bursty input and stalled output,
// predicts mean, deviation and bands per item and checks every result.
// ----------------------------------------------------------------------------
module tb_bollinger_band_window;
	import bbw_pkg::*;

	typedef struct packed {
		logic [31:0] close_price;
		logic        restart;
	} price_item_t;

	typedef struct packed {
		logic [31:0] middle_band;
		logic [36:0] upper_band;
		logic [36:0] lower_band;
		logic [31:0] deviation;
	} band_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = REG_WINDOW_LENGTH;
	logic [CfgDataW-1:0] cfg_data = '0;

	bbw_stream_if #(.payload_t(price_item_t)) in_ch ();
	bbw_stream_if #(.payload_t(band_item_t)) out_ch ();

	bollinger_band_window dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [31:0] hist [64];
	logic [5:0]  hist_pos = '0;
	logic [6:0]  hist_fill = '0;
	logic [6:0]  cur_len = 7'd20;
	logic [11:0] cur_mult = 12'd512;

	price_item_t pending_prices[$];
	band_item_t  expected_bands[$];
	int errors = 0;
	int produced = 0;

	task automatic predict_bands(input price_item_t it);
		int n;
		logic [63:0] sum;
		logic [31:0] mean;
		logic [31:0] p;
		logic [31:0] d;
		logic [127:0] ssd;
		logic [127:0] var_q;
		logic [63:0] cand;
		logic [31:0] root;
		logic [43:0] offset;
		band_item_t r;
		if (it.restart) begin
			hist_fill = '0;
			hist_pos = '0;
		end
		hist[hist_pos] = it.close_price;
		hist_pos = hist_pos + 6'd1;
		if (hist_fill < 7'd64)
			hist_fill = hist_fill + 7'd1;
		n = cur_len;
		if (n == 0) n = 1;
		if (n > 64) n = 64;
		if (hist_fill < n)
			return;
		sum = '0;
		for (int k = 1; k <= n; k++)
			sum += hist[6'(hist_pos - k)];
		mean = 32'(sum / n);
		ssd = '0;
		for (int k = 1; k <= n; k++) begin
			p = hist[6'(hist_pos - k)];
			d = (p >= mean) ? p - mean : mean - p;
			ssd += {96'b0, d} * {96'b0, d};
		end
		var_q = ssd / n;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			cand = {32'b0, root | (32'd1 << b)};
			if ({64'b0, cand} * {64'b0, cand} <= var_q)
				root = cand[31:0];
		end
		offset = ({32'b0, cur_mult} * {12'b0, root}) >> 8;
		r.middle_band = mean;
		r.upper_band = 37'(mean) + 37'(offset);
		r.lower_band = 37'(mean) - 37'(offset);
		r.deviation = root;
		expected_bands.push_back(r);
	endtask

	// driver
	logic in_valid = 1'b0;
	price_item_t in_data = '0;
	logic in_acc = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	assign in_ch.valid = in_valid;
	assign in_ch.data = in_data;

	always @(posedge clk) in_acc <= in_ch.valid && in_ch.ready;

	always @(negedge clk) begin
		logic nv;
		price_item_t nd;
		nv = in_valid;
		nd = in_data;
		if (arst_n && (!in_valid || in_acc)) begin
			nv = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_prices.size() > 0) begin
				nd = pending_prices.pop_front();
				nv = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
					gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
				end
			end
		end
		in_valid <= nv;
		in_data <= nd;
	end

	// receiver stall pattern
	logic out_ready = 1'b0;
	int stall_mode = 0;
	int stall_cnt = 0;
	assign out_ch.ready = out_ready;

	always @(negedge clk) begin
		stall_cnt++;
		if (stall_cnt % 300 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
		0: out_ready <= 1'b1;
		1: out_ready <= $urandom_range(0, 1);
		2: out_ready <= (stall_cnt % 7) < 2;
		default: out_ready <= (stall_cnt % 150) > 120;
		endcase
	end

	// monitor
	always @(posedge clk) begin
		band_item_t want;
		band_item_t got;
		if (arst_n && in_ch.valid && in_ch.ready)
			predict_bands(in_ch.data);
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			produced++;
			if (expected_bands.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = expected_bands.pop_front();
				if (got.middle_band !== want.middle_band) begin
					$display("%0t: middle_band exp %h got %h", $time,
						want.middle_band, got.middle_band);
					errors++;
				end
				if (got.upper_band !== want.upper_band) begin
					$display("%0t: upper_band exp %h got %h", $time,
						want.upper_band, got.upper_band);
					errors++;
				end
				if (got.lower_band !== want.lower_band) begin
					$display("%0t: lower_band exp %h got %h", $time,
						want.lower_band, got.lower_band);
					errors++;
				end
				if (got.deviation !== want.deviation) begin
					$display("%0t: deviation exp %h got %h", $time,
						want.deviation, got.deviation);
					errors++;
				end
			end
		end
	end

	task automatic drain_block;
		while (pending_prices.size() > 0 || in_valid || expected_bands.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CfgDataW'(val);
		@(posedge clk);
		if (idx == REG_WINDOW_LENGTH)
			cur_len = 7'(val);
		else
			cur_mult = 12'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_bands(input int len, input int mult);
		drain_block();
		write_reg(REG_WINDOW_LENGTH, len);
		write_reg(REG_BAND_MULTIPLIER, mult);
	endtask

	task automatic queue_price(input logic [31:0] p, input logic rs);
		price_item_t it;
		it.close_price = p;
		it.restart = rs;
		pending_prices.push_back(it);
	endtask

	function automatic logic [31:0] random_price(input logic [31:0] base);
		case ($urandom_range(0, 9))
		0: return 32'hFFFF_FFFF;
		1: return 32'h0;
		2, 3: return $urandom;
		default: return base + $urandom_range(0, 4096) - 32'd2048;
		endcase
	endfunction

	initial begin
		int lens[6];
		int mults[6];
		int sent;
		int plen;
		logic [31:0] base;
		lens = '{0, 127, 64, 1, 2, 33};
		mults = '{4095, 0, 4095, 256, 1, 512};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// length zero acts as one, widest multiplier
		set_bands(0, 4095);
		queue_price(32'h0, 1'b1);
		queue_price(32'hFFFF_FFFF, 1'b0);
		queue_price(32'h1, 1'b0);
		queue_price(32'h8000_0000, 1'b0);
		// two-price window swinging across the full range: negative lower band
		set_bands(2, 4095);
		queue_price(32'h0, 1'b1);
		queue_price(32'hFFFF_FFFF, 1'b0);
		queue_price(32'h0, 1'b0);
		queue_price(32'hFFFF_FFFF, 1'b0);
		queue_price(32'h5555_5555, 1'b0);
		queue_price(32'hAAAA_AAAA, 1'b1);
		queue_price(32'h1234_5678, 1'b0);
		// lengthen mid-stream: history is kept
		set_bands(4, 0);
		queue_price(32'h0000_0100, 1'b0);
		queue_price(32'h0000_0300, 1'b0);
		queue_price(32'hFFFF_FF00, 1'b0);
		queue_price(32'h7FFF_FFFF, 1'b0);
		// shrink with a short history after restart
		set_bands(3, 256);
		queue_price(32'hFFFF_FFFF, 1'b1);
		queue_price(32'hFFFF_FFFF, 1'b0);
		queue_price(32'hFFFF_FFFF, 1'b0);
		queue_price(32'h0, 1'b0);
		queue_price(32'h1, 1'b0);

		sent = 0;
		for (int ph = 0; sent < 900; ph++) begin
			if (ph < 6)
				set_bands(lens[ph], mults[ph]);
			else if ($urandom_range(0, 3) == 0)
				set_bands($urandom_range(0, 127), $urandom_range(0, 4095));
			else
				set_bands($urandom_range(1, 24), $urandom_range(0, 4095));
			plen = $urandom_range(60, 150);
			if (cur_len == 0 || cur_len > 40)
				plen = 150;
			base = $urandom;
			for (int i = 0; i < plen; i++) begin
				queue_price(random_price(base), ($urandom_range(0, 99) < 2) || i == 0);
				sent++;
			end
		end

		drain_block();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#40ms;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+design
design/bbw_pkg.sv
design/bbw_stream_if.sv
design/bbw_ram.sv
design/bbw_datapath.sv
design/bbw_ctrl.sv
design/bollinger_band_window.sv
bench/tb_bollinger_band_window.sv
